>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and widths shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH;
    localparam int CHAIN_LEN   = WIDE_WIDTH + 1;
    localparam int CNT_W       = $clog2(WIDE_WIDTH + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]                    op;
        logic signed [VALUE_WIDTH-1:0] a_num;
        logic signed [VALUE_WIDTH-1:0] a_den;
        logic signed [VALUE_WIDTH-1:0] b_num;
        logic signed [VALUE_WIDTH-1:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] res_num;
        logic [VALUE_WIDTH-2:0]        res_den;
        logic                          is_equal;
        logic [1:0]                    status;
    } rau_out_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHLADD,
        CELL_SHR,
        CELL_SUBSWAP,
        CELL_DIVSTEP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     add_en;
        logic     shr_a;
        logic     shr_b;
    } cell_ctrl_t;

endpackage

>>> rtl/core/rau_cell.sv
// ----------------------------------------------------------------------------
// rau_cell
// One bit slice of the shift / add / subtract chain: holds one bit of the
// A and B words and passes carry and shift bits to its neighbors.
// ----------------------------------------------------------------------------
module rau_cell
    import rau_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       sel,
    input  logic       a_lo,
    input  logic       a_hi,
    input  logic       b_hi,
    input  logic       cin,
    input  logic       ld_a,
    input  logic       ld_b,
    output logic       a,
    output logic       b,
    output logic       cout
);

    logic a_reg, a_next;
    logic b_reg, b_next;
    logic x, y, s;

    always_comb
    begin
        x = 1'b0;
        y = 1'b0;
        unique case (ctrl.op)
            CELL_SHLADD:
            begin
                x = a_lo;
                y = b_reg & ctrl.add_en;
            end
            CELL_SUBSWAP:
            begin
                x = b_reg;
                y = ~a_reg;
            end
            CELL_DIVSTEP:
            begin
                x = a_lo;
                y = ~b_reg;
            end
            default:
            begin
                x = 1'b0;
                y = 1'b0;
            end
        endcase
        s    = x ^ y ^ cin;
        cout = (x & y) | (cin & (x ^ y));
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        unique case (ctrl.op)
            CELL_LOAD:
            begin
                a_next = ld_a;
                b_next = ld_b;
            end
            CELL_SHLADD:
            begin
                a_next = s;
            end
            CELL_SHR:
            begin
                if (ctrl.shr_a)
                begin
                    a_next = a_hi;
                end
                if (ctrl.shr_b)
                begin
                    b_next = b_hi;
                end
            end
            CELL_SUBSWAP:
            begin
                // sel set: B >= A, so B takes the difference; else swap
                if (sel)
                begin
                    b_next = s;
                end
                else
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            CELL_DIVSTEP:
            begin
                a_next = sel ? s : a_lo;
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a = a_reg;
    assign b = b_reg;

endmodule

>>> rtl/core/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply, divide and equality test on two fractions.
// ----------------------------------------------------------------------------
// One item at a time. The cross products (two for compare, three otherwise)
// come from a shift-add multiply on a chain of 2*W+1 bit cells. The chain
// then runs a binary GCD of shifts, subtracts and swaps, plus the restore
// shift. Two restoring divisions then reduce the numerator and denominator
// by the GCD. Invalid items skip all of this, compare finishes after the
// cross products, and a zero result skips the GCD and the divisions.
// ----------------------------------------------------------------------------
module rational_arith_unit
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rau_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output rau_out_t out_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int WW = WIDE_WIDTH;
    localparam int NC = CHAIN_LEN;

    localparam logic [WW-1:0] DEN_MAX = {{(WW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic [WW-1:0] NEG_MAX = DEN_MAX + {{(WW - 1){1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_LD, S_MUL, S_MUL_ST, S_FORM, S_GCD_K, S_GCD_U, S_GCD_V,
        S_GCD_SHL, S_DIV_LD, S_DIV, S_DIV_ST, S_DONE
    } state_t;

    function automatic logic [VW-1:0] mag(input logic [VW-1:0] x);
        return x[VW-1] ? (~x + 1'b1) : x;
    endfunction

    state_t          state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [VW-1:0]   an_reg, an_next, ad_reg, ad_next;
    logic [VW-1:0]   bn_reg, bn_next, bd_reg, bd_next;
    logic [3:0]      sgn_reg, sgn_next;          // {an, ad, bn, bd}
    logic [1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [VW-1:0]   my_reg, my_next;
    logic [WW-1:0]   t1_reg, t1_next, t2_reg, t2_next, dm_reg, dm_next;
    logic [WW-1:0]   nm_reg, nm_next, g_reg, g_next;
    logic [WW-1:0]   nsh_reg, nsh_next, q_reg, q_next, qn_reg, qn_next;
    logic            neg_reg, neg_next;
    logic            div_idx_reg, div_idx_next;
    rau_out_t        res_reg, res_next;
    rau_out_t        out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    cell_ctrl_t      ctrl;
    logic            lsb_in;
    logic [NC-1:0]   ld_a, ld_b;
    logic [NC-1:0]   a_vec, b_vec;
    logic [NC:0]     carry;
    logic            sel;

    logic [VW-1:0]   in_an, in_ad, in_bn, in_bd;
    logic [VW-1:0]   mx, mbits;
    logic            s1, s2, eq;
    logic [WW:0]     diff;
    logic [WW-1:0]   nm_f, sum12;
    logic            ns;
    logic            ovf;

    assign carry[0] = (ctrl.op == CELL_SUBSWAP) || (ctrl.op == CELL_DIVSTEP);
    assign sel      = carry[NC];

    for (genvar i = 0; i < NC; i++)
    begin : g_chain
        logic lo, hi_a, hi_b;
        if (i == 0)
        begin : g_first
            assign lo = lsb_in;
        end
        else
        begin : g_mid
            assign lo = a_vec[i-1];
        end
        if (i == NC - 1)
        begin : g_last
            assign hi_a = 1'b0;
            assign hi_b = 1'b0;
        end
        else
        begin : g_inner
            assign hi_a = a_vec[i+1];
            assign hi_b = b_vec[i+1];
        end
        rau_cell u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .sel  (sel),
            .a_lo (lo),
            .a_hi (hi_a),
            .b_hi (hi_b),
            .cin  (carry[i]),
            .ld_a (ld_a[i]),
            .ld_b (ld_b[i]),
            .a    (a_vec[i]),
            .b    (b_vec[i]),
            .cout (carry[i+1])
        );
    end

    assign in_an = mag(in_data.a_num);
    assign in_ad = mag(in_data.a_den);
    assign in_bn = mag(in_data.b_num);
    assign in_bd = mag(in_data.b_den);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        sgn_next       = sgn_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        my_next        = my_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        dm_next        = dm_reg;
        nm_next        = nm_reg;
        g_next         = g_reg;
        nsh_next       = nsh_reg;
        q_next         = q_reg;
        qn_next        = qn_reg;
        neg_next       = neg_reg;
        div_idx_next   = div_idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        ctrl   = '{op: CELL_HOLD, add_en: 1'b0, shr_a: 1'b0, shr_b: 1'b0};
        lsb_in = 1'b0;
        ld_a   = '0;
        ld_b   = '0;
        mx     = '0;
        mbits  = '0;

        s1    = sgn_reg[3] ^ sgn_reg[0];
        s2    = sgn_reg[1] ^ sgn_reg[2] ^ (op_reg == OP_SUB);
        eq    = ((t1_reg == '0) && (t2_reg == '0)) ||
                ((t1_reg == t2_reg) && (s1 == (sgn_reg[1] ^ sgn_reg[2])));
        sum12 = t1_reg + t2_reg;
        diff  = {1'b0, t1_reg} - {1'b0, t2_reg};
        nm_f  = t1_reg;
        ns    = s1;
        ovf   = (qn_reg > (neg_reg ? NEG_MAX : DEN_MAX)) || (q_reg > DEN_MAX);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_data.op;
                    an_next  = in_an;
                    ad_next  = in_ad;
                    bn_next  = in_bn;
                    bd_next  = in_bd;
                    sgn_next = {in_data.a_num[VW-1], in_data.a_den[VW-1],
                                in_data.b_num[VW-1], in_data.b_den[VW-1]};
                    idx_next = '0;
                    if ((in_data.op > OP_CMP) || (in_ad == '0) || (in_bd == '0) ||
                        ((in_data.op == OP_DIV) && (in_bn == '0)))
                    begin
                        res_next        = '0;
                        res_next.status = ST_INVALID;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL_LD;
                    end
                end
            end
            S_MUL_LD:
            begin
                unique case (idx_reg)
                    2'd0:
                    begin
                        mx    = an_reg;
                        mbits = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                    end
                    2'd1:
                    begin
                        mx    = bn_reg;
                        mbits = ad_reg;
                    end
                    default:
                    begin
                        mx    = ad_reg;
                        mbits = (op_reg == OP_DIV) ? bn_reg : bd_reg;
                    end
                endcase
                ctrl.op    = CELL_LOAD;
                ld_b       = NC'(mx);
                my_next    = mbits;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ctrl.op     = CELL_SHLADD;
                ctrl.add_en = my_reg[VW-1];
                my_next     = {my_reg[VW-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VW - 1))
                begin
                    state_next = S_MUL_ST;
                end
            end
            S_MUL_ST:
            begin
                unique case (idx_reg)
                    2'd0:    t1_next = a_vec[WW-1:0];
                    2'd1:    t2_next = a_vec[WW-1:0];
                    default: dm_next = a_vec[WW-1:0];
                endcase
                if ((idx_reg == 2'd2) || ((idx_reg == 2'd1) && (op_reg == OP_CMP)))
                begin
                    state_next = S_FORM;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MUL_LD;
                end
            end
            S_FORM:
            begin
                if (op_reg == OP_CMP)
                begin
                    res_next          = '0;
                    res_next.is_equal = eq;
                    res_next.status   = ST_OK;
                    state_next        = S_DONE;
                end
                else
                begin
                    if ((op_reg == OP_ADD) || (op_reg == OP_SUB))
                    begin
                        priority if (s1 == s2)
                        begin
                            nm_f = sum12;
                            ns   = s1;
                        end
                        else if (!diff[WW])
                        begin
                            nm_f = diff[WW-1:0];
                            ns   = s1;
                        end
                        else
                        begin
                            nm_f = ~diff[WW-1:0] + 1'b1;
                            ns   = s2;
                        end
                        neg_next = ns ^ sgn_reg[2] ^ sgn_reg[0];
                    end
                    else
                    begin
                        nm_f     = t1_reg;
                        neg_next = ^sgn_reg;
                    end
                    if (nm_f == '0)
                    begin
                        res_next         = '0;
                        res_next.res_den = (VW-1)'(1);
                        res_next.status  = ST_OK;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        ctrl.op    = CELL_LOAD;
                        ld_a       = NC'(nm_f);
                        ld_b       = NC'(dm_reg);
                        nm_next    = nm_f;
                        k_next     = '0;
                        state_next = S_GCD_K;
                    end
                end
            end
            S_GCD_K:
            begin
                // strip common factors of two
                if (!a_vec[0] && !b_vec[0])
                begin
                    ctrl.op    = CELL_SHR;
                    ctrl.shr_a = 1'b1;
                    ctrl.shr_b = 1'b1;
                    k_next     = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_GCD_U;
                end
            end
            S_GCD_U:
            begin
                if (!a_vec[0])
                begin
                    ctrl.op    = CELL_SHR;
                    ctrl.shr_a = 1'b1;
                end
                else
                begin
                    state_next = S_GCD_V;
                end
            end
            S_GCD_V:
            begin
                priority if (b_vec == '0)
                begin
                    state_next = S_GCD_SHL;
                end
                else if (!b_vec[0])
                begin
                    ctrl.op    = CELL_SHR;
                    ctrl.shr_b = 1'b1;
                end
                else
                begin
                    ctrl.op = CELL_SUBSWAP;
                end
            end
            S_GCD_SHL:
            begin
                if (k_reg != '0)
                begin
                    ctrl.op = CELL_SHLADD;
                    k_next  = k_reg - 1'b1;
                end
                else
                begin
                    g_next       = a_vec[WW-1:0];
                    div_idx_next = 1'b0;
                    state_next   = S_DIV_LD;
                end
            end
            S_DIV_LD:
            begin
                ctrl.op    = CELL_LOAD;
                ld_b       = NC'(g_reg);
                nsh_next   = div_idx_reg ? dm_reg : nm_reg;
                cnt_next   = '0;
                q_next     = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctrl.op  = CELL_DIVSTEP;
                lsb_in   = nsh_reg[WW-1];
                nsh_next = {nsh_reg[WW-2:0], 1'b0};
                q_next   = {q_reg[WW-2:0], sel};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WW - 1))
                begin
                    state_next = S_DIV_ST;
                end
            end
            S_DIV_ST:
            begin
                if (!div_idx_reg)
                begin
                    qn_next      = q_reg;
                    div_idx_next = 1'b1;
                    state_next   = S_DIV_LD;
                end
                else
                begin
                    res_next = '0;
                    if (ovf)
                    begin
                        res_next.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        res_next.res_num = neg_reg ? (~qn_reg[VW-1:0] + 1'b1)
                                                   : qn_reg[VW-1:0];
                        res_next.res_den = q_reg[VW-2:0];
                        res_next.status  = ST_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        sgn_reg     <= sgn_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        k_reg       <= k_next;
        my_reg      <= my_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        dm_reg      <= dm_next;
        nm_reg      <= nm_next;
        g_reg       <= g_next;
        nsh_reg     <= nsh_next;
        q_reg       <= q_next;
        qn_reg      <= qn_next;
        neg_reg     <= neg_next;
        div_idx_reg <= div_idx_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
